>>> rtl/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg: shared types, constants and helpers for the joint space steer core
// Angle formats, pipeline stage numbering and the half-turn wrap function.
// ----------------------------------------------------------------------------
package jss_pkg;

  // Angle format: signed fixed point, 1/64 degree
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANGLE_W         = 15;
  localparam int MAG_W           = ANGLE_W - 1;
  localparam int LIMIT_W         = 14;
  localparam int PROD_W          = MAG_W + LIMIT_W;
  localparam int WIDE_W          = ANGLE_W + 3;
  localparam int LANES           = 4;

  // Pipeline: front, multiply, one stage per quotient bit, output
  localparam int DIV_STEPS  = LIMIT_W;
  localparam int STAGE_MUL  = 1;
  localparam int STAGE_DIV0 = 2;
  localparam int STAGE_OUT  = STAGE_DIV0 + DIV_STEPS;
  localparam int NSTAGE     = STAGE_OUT + 1;

  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = LIMIT_W'(640);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [NSTAGE-1:0]         stage_vec_t;

  localparam wide_t HALF_TURN = WIDE_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam wide_t FULL_TURN = WIDE_W'(360 * (1 << ANGLE_FRAC_BITS));

  // Map x into [-HALF_TURN, HALF_TURN); inputs stay within one turn of range
  function automatic angle_t wrap_angle(input wide_t x);
    wide_t m;
    begin
      m = x + HALF_TURN;
      if (m < 0) begin
        m = m + FULL_TURN;
      end else if (m >= FULL_TURN) begin
        m = m - FULL_TURN;
      end
      m = m - HALF_TURN;
      return angle_t'(m[ANGLE_W-1:0]);
    end
  endfunction

endpackage

>>> rtl/jss_merge.sv
// ----------------------------------------------------------------------------
// jss_merge: combine the per-joint magnitudes of all lanes
// Finds the largest difference magnitude, decides reduction and carries the
// reduce flag down the pipeline alongside the lane dividers.
// ----------------------------------------------------------------------------
module jss_merge (
  input  logic                                   clk,
  input  jss_pkg::stage_vec_t                    load,
  input  logic [jss_pkg::LANES-1:0][jss_pkg::MAG_W-1:0] lane_mag,
  input  jss_pkg::limit_t                        step_limit,
  output jss_pkg::mag_t                          max_mag,
  output logic                                   reduce_final,
  output logic                                   reduced
);

  jss_pkg::mag_t max01;
  jss_pkg::mag_t max23;
  jss_pkg::mag_t max_all;
  logic          reduce;
  logic [jss_pkg::STAGE_OUT:jss_pkg::STAGE_MUL] red_q;

  // Two-level compare tree over the lane magnitudes
  always_comb begin
    max01   = (lane_mag[0] > lane_mag[1]) ? lane_mag[0] : lane_mag[1];
    max23   = (lane_mag[2] > lane_mag[3]) ? lane_mag[2] : lane_mag[3];
    max_all = (max01 > max23) ? max01 : max23;
    reduce  = max_all > step_limit;
  end

  // Hold the divisor for the first divider stage
  always_ff @(posedge clk) begin
    if (load[jss_pkg::STAGE_MUL]) begin
      max_mag <= max_all;
    end
  end

  // Advance the reduce flag with its item
  always_ff @(posedge clk) begin
    if (load[jss_pkg::STAGE_MUL]) begin
      red_q[jss_pkg::STAGE_MUL] <= reduce;
    end
    for (int k = jss_pkg::STAGE_MUL + 1; k <= jss_pkg::STAGE_OUT; k++) begin
      if (load[k]) begin
        red_q[k] <= red_q[k-1];
      end
    end
  end

  assign reduce_final = red_q[jss_pkg::STAGE_OUT-1];
  assign reduced      = red_q[jss_pkg::STAGE_OUT];

endmodule

>>> rtl/jss_lane.sv
// ----------------------------------------------------------------------------
// jss_lane: one joint of the steer step
// Wrapped difference, scaled move by a pipelined restoring divider (one
// quotient bit per stage), then the new angle with wrap and target select.
// ----------------------------------------------------------------------------
module jss_lane (
  input  logic                clk,
  input  jss_pkg::stage_vec_t load,
  input  jss_pkg::angle_t     target_angle,
  input  jss_pkg::angle_t     near_angle,
  input  jss_pkg::limit_t     step_limit,
  input  jss_pkg::mag_t       max_mag,
  input  logic                reduce_final,
  output jss_pkg::mag_t       diff_mag,
  output jss_pkg::angle_t     new_angle
);

  localparam int N = jss_pkg::DIV_STEPS;

  // Front stage
  jss_pkg::angle_t diff_c;
  jss_pkg::angle_t target_wrap_c;
  logic            diff_neg;
  jss_pkg::angle_t near0;
  jss_pkg::angle_t tw0;

  // Multiply stage
  jss_pkg::prod_t  prod1;
  logic            sgn1;
  jss_pkg::angle_t near1;
  jss_pkg::angle_t tw1;

  // Divider stages
  jss_pkg::mag_t   rem_q   [N];
  jss_pkg::mag_t   low_q   [N];
  jss_pkg::mag_t   quo_q   [N];
  jss_pkg::mag_t   dvs_q   [N];
  logic            sgn_q   [N];
  jss_pkg::angle_t near_q  [N];
  jss_pkg::angle_t tw_q    [N];
  jss_pkg::mag_t   rem_next[N];
  jss_pkg::mag_t   low_next[N];
  jss_pkg::mag_t   quo_next[N];

  // Output stage
  jss_pkg::wide_t  move_c;
  jss_pkg::angle_t new_c;

  // Wrapped difference and wrapped target
  always_comb begin
    diff_c        = jss_pkg::wrap_angle(jss_pkg::wide_t'(target_angle) -
                                        jss_pkg::wide_t'(near_angle));
    target_wrap_c = jss_pkg::wrap_angle(jss_pkg::wide_t'(target_angle));
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      diff_neg <= diff_c[jss_pkg::ANGLE_W-1];
      diff_mag <= diff_c[jss_pkg::ANGLE_W-1] ? jss_pkg::mag_t'(-diff_c)
                                             : jss_pkg::mag_t'(diff_c);
      near0    <= near_angle;
      tw0      <= target_wrap_c;
    end
  end

  // Scale the magnitude by the limit
  always_ff @(posedge clk) begin
    if (load[jss_pkg::STAGE_MUL]) begin
      prod1 <= jss_pkg::PROD_W'(diff_mag) * jss_pkg::PROD_W'(step_limit);
      sgn1  <= diff_neg;
      near1 <= near0;
      tw1   <= tw0;
    end
  end

  // One restoring step per stage: bring down a dividend bit, subtract if fits
  always_comb begin
    jss_pkg::mag_t         r_in;
    jss_pkg::mag_t         l_in;
    jss_pkg::mag_t         q_in;
    jss_pkg::mag_t         d_in;
    logic [jss_pkg::MAG_W:0] t;
    logic [jss_pkg::MAG_W:0] t_sub;
    logic                  fits;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        r_in = prod1[jss_pkg::PROD_W-1:jss_pkg::LIMIT_W];
        l_in = prod1[jss_pkg::LIMIT_W-1:0];
        q_in = '0;
        d_in = max_mag;
      end else begin
        r_in = rem_q[s-1];
        l_in = low_q[s-1];
        q_in = quo_q[s-1];
        d_in = dvs_q[s-1];
      end
      t           = {r_in, l_in[jss_pkg::MAG_W-1]};
      t_sub       = t - {1'b0, d_in};
      fits        = t >= {1'b0, d_in};
      rem_next[s] = fits ? t_sub[jss_pkg::MAG_W-1:0] : t[jss_pkg::MAG_W-1:0];
      low_next[s] = {l_in[jss_pkg::MAG_W-2:0], 1'b0};
      quo_next[s] = {q_in[jss_pkg::MAG_W-2:0], fits};
    end
  end

  // Advance the divider stages
  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (load[jss_pkg::STAGE_DIV0 + s]) begin
        rem_q[s] <= rem_next[s];
        low_q[s] <= low_next[s];
        quo_q[s] <= quo_next[s];
        if (s == 0) begin
          dvs_q[s]  <= max_mag;
          sgn_q[s]  <= sgn1;
          near_q[s] <= near1;
          tw_q[s]   <= tw1;
        end else begin
          dvs_q[s]  <= dvs_q[s-1];
          sgn_q[s]  <= sgn_q[s-1];
          near_q[s] <= near_q[s-1];
          tw_q[s]   <= tw_q[s-1];
        end
      end
    end
  end

  // Apply the signed move and wrap, or pass the wrapped target
  always_comb begin
    move_c = sgn_q[N-1] ? -jss_pkg::wide_t'(quo_q[N-1]) : jss_pkg::wide_t'(quo_q[N-1]);
    new_c  = reduce_final
           ? jss_pkg::wrap_angle(jss_pkg::wide_t'(near_q[N-1]) + move_c)
           : tw_q[N-1];
  end

  always_ff @(posedge clk) begin
    if (load[jss_pkg::STAGE_OUT]) begin
      new_angle <= new_c;
    end
  end

endmodule

>>> rtl/joint_space_steer_core.sv
// ----------------------------------------------------------------------------
// joint_space_steer_core: step-limited steer toward a sampled target
// Four joint lanes, merge stage; pipelined, one item per cycle when unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   Steer channel: present target_angle_0..3 and near_angle_0..3 with
//   steer_valid; the item is taken on a clock edge where steer_stall is low.
//   Result channel: new_angle_0..3 and was_reduced come with result_valid
//   and hold while result_stall is high.
//   Config channel: cfg_data sets step_limit when cfg_valid and cfg_ready
//   are both high; cfg_ready is always high. Write only while idle.
// Pipeline:
//   An accepted item reaches result_valid through 17 registers: one front
//   stage, one multiply and max stage, 14 divider stages (one quotient bit
//   each, set by the 14-bit limit) and the output register.
// Reset and stall:
//   rst empties the pipeline and sets step_limit to 640. A stalled result
//   holds in the output register; earlier stages keep filling their bubbles
//   and steer_stall rises only when every stage holds an item.
// ----------------------------------------------------------------------------
module joint_space_steer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             steer_valid,
  output logic             steer_stall,
  input  jss_pkg::angle_t  target_angle_0,
  input  jss_pkg::angle_t  target_angle_1,
  input  jss_pkg::angle_t  target_angle_2,
  input  jss_pkg::angle_t  target_angle_3,
  input  jss_pkg::angle_t  near_angle_0,
  input  jss_pkg::angle_t  near_angle_1,
  input  jss_pkg::angle_t  near_angle_2,
  input  jss_pkg::angle_t  near_angle_3,
  output logic             result_valid,
  input  logic             result_stall,
  output jss_pkg::angle_t  new_angle_0,
  output jss_pkg::angle_t  new_angle_1,
  output jss_pkg::angle_t  new_angle_2,
  output jss_pkg::angle_t  new_angle_3,
  output logic             was_reduced,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  jss_pkg::limit_t  cfg_data
);

  localparam int NS = jss_pkg::NSTAGE;

  jss_pkg::limit_t    step_limit;
  jss_pkg::stage_vec_t valid_q;
  jss_pkg::stage_vec_t load;
  jss_pkg::angle_t    tgt  [jss_pkg::LANES];
  jss_pkg::angle_t    nr   [jss_pkg::LANES];
  jss_pkg::angle_t    newa [jss_pkg::LANES];
  logic [jss_pkg::LANES-1:0][jss_pkg::MAG_W-1:0] lane_mag;
  jss_pkg::mag_t      max_mag;
  logic               reduce_final;

  // Limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= jss_pkg::STEP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_limit <= cfg_data;
    end
  end

  // A stage loads when it or some stage after it is empty, or the output drains
  always_comb begin
    stage_vec_t_block : begin
      jss_pkg::stage_vec_t below;
      for (int k = 0; k < NS; k++) begin
        below   = (jss_pkg::stage_vec_t'(1) << k) - jss_pkg::stage_vec_t'(1);
        load[k] = !result_stall || !(&(valid_q | below));
      end
    end
  end

  assign steer_stall  = !load[0];
  assign result_valid = valid_q[jss_pkg::STAGE_OUT];

  // Advance the item valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= steer_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign tgt[0] = target_angle_0;
  assign tgt[1] = target_angle_1;
  assign tgt[2] = target_angle_2;
  assign tgt[3] = target_angle_3;
  assign nr[0]  = near_angle_0;
  assign nr[1]  = near_angle_1;
  assign nr[2]  = near_angle_2;
  assign nr[3]  = near_angle_3;

  // Joint lanes
  for (genvar g = 0; g < jss_pkg::LANES; g++) begin : g_lane
    jss_lane u_lane (
      .clk          (clk),
      .load         (load),
      .target_angle (tgt[g]),
      .near_angle   (nr[g]),
      .step_limit   (step_limit),
      .max_mag      (max_mag),
      .reduce_final (reduce_final),
      .diff_mag     (lane_mag[g]),
      .new_angle    (newa[g])
    );
  end

  // Largest difference and reduce decision
  jss_merge u_merge (
    .clk          (clk),
    .load         (load),
    .lane_mag     (lane_mag),
    .step_limit   (step_limit),
    .max_mag      (max_mag),
    .reduce_final (reduce_final),
    .reduced      (was_reduced)
  );

  assign new_angle_0 = newa[0];
  assign new_angle_1 = newa[1];
  assign new_angle_2 = newa[2];
  assign new_angle_3 = newa[3];

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the joint space steer core
// Drives steer requests through the valid/stall channel, predicts each steered
// state from a behavioral model kept in the bench, and compares every result
// field by field. Covers the step limit at reset, at zero, just below, at and
// above a half turn, angles outside the wrapped range, random traffic under
// several idle/stall mixes and a long result hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     LANES       = jss_pkg::LANES;
  localparam longint HALF_SPAN   = longint'(180) << jss_pkg::ANGLE_FRAC_BITS;
  localparam longint FULL_SPAN   = 2 * HALF_SPAN;
  localparam int     PIPE_DEPTH  = 17;
  localparam int     HOLD_LEN    = 300;
  localparam int     PHASE_ITEMS = 240;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     REPORT_CAP  = 100;

  typedef struct {
    jss_pkg::angle_t angle [LANES];
    logic            reduced;
  } steer_out_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            steer_valid = 1'b0;
  logic            steer_stall;
  jss_pkg::angle_t target_angle_0 = '0;
  jss_pkg::angle_t target_angle_1 = '0;
  jss_pkg::angle_t target_angle_2 = '0;
  jss_pkg::angle_t target_angle_3 = '0;
  jss_pkg::angle_t near_angle_0 = '0;
  jss_pkg::angle_t near_angle_1 = '0;
  jss_pkg::angle_t near_angle_2 = '0;
  jss_pkg::angle_t near_angle_3 = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  jss_pkg::angle_t new_angle_0;
  jss_pkg::angle_t new_angle_1;
  jss_pkg::angle_t new_angle_2;
  jss_pkg::angle_t new_angle_3;
  logic            was_reduced;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  jss_pkg::limit_t cfg_data = '0;

  steer_out_t      expected_steers [$];
  jss_pkg::limit_t step_limit_now = jss_pkg::STEP_LIMIT_RESET;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  bit              valid_held = 1'b0;
  logic            hold_start = 1'b0;
  int              hold_cycles = 0;
  int              mismatch_count = 0;
  int              cycle_count = 0;

  joint_space_steer_core dut (
    .clk            (clk),
    .rst            (rst),
    .steer_valid    (steer_valid),
    .steer_stall    (steer_stall),
    .target_angle_0 (target_angle_0),
    .target_angle_1 (target_angle_1),
    .target_angle_2 (target_angle_2),
    .target_angle_3 (target_angle_3),
    .near_angle_0   (near_angle_0),
    .near_angle_1   (near_angle_1),
    .near_angle_2   (near_angle_2),
    .near_angle_3   (near_angle_3),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .new_angle_0    (new_angle_0),
    .new_angle_1    (new_angle_1),
    .new_angle_2    (new_angle_2),
    .new_angle_3    (new_angle_3),
    .was_reduced    (was_reduced),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Count down the long result hold-off once it is requested
  always @(posedge clk) begin
    if (hold_start) begin
      hold_cycles <= HOLD_LEN;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Bring any angle into [-half turn, half turn)
  function automatic longint wrap_turn(input longint x);
    longint m;
    m = (x + HALF_SPAN) % FULL_SPAN;
    if (m < 0) begin
      m += FULL_SPAN;
    end
    return m - HALF_SPAN;
  endfunction

  // Steer one joint state toward its target under the step limit
  function automatic steer_out_t steer_predict(input jss_pkg::angle_t tg [LANES],
                                               input jss_pkg::angle_t nr [LANES],
                                               input jss_pkg::limit_t lim);
    steer_out_t res;
    longint     delta [LANES];
    longint     maxabs;
    longint     mag;
    longint     lim_w;
    maxabs = 0;
    lim_w  = longint'(lim);
    for (int i = 0; i < LANES; i++) begin
      delta[i] = wrap_turn(longint'(tg[i]) - longint'(nr[i]));
      mag = (delta[i] < 0) ? -delta[i] : delta[i];
      if (mag > maxabs) begin
        maxabs = mag;
      end
    end
    res.reduced = (maxabs > lim_w);
    for (int i = 0; i < LANES; i++) begin
      if (res.reduced) begin
        res.angle[i] = jss_pkg::angle_t'(wrap_turn(longint'(nr[i]) +
                                                   (delta[i] * lim_w) / maxabs));
      end else begin
        res.angle[i] = jss_pkg::angle_t'(wrap_turn(longint'(tg[i])));
      end
    end
    return res;
  endfunction

  // Offer one item, hold it until taken, then maybe idle the sender
  task automatic send_steer(input int t0, input int t1, input int t2, input int t3,
                            input int n0, input int n1, input int n2, input int n3);
    jss_pkg::angle_t tg [LANES];
    jss_pkg::angle_t nr [LANES];
    tg = '{jss_pkg::angle_t'(t0), jss_pkg::angle_t'(t1),
           jss_pkg::angle_t'(t2), jss_pkg::angle_t'(t3)};
    nr = '{jss_pkg::angle_t'(n0), jss_pkg::angle_t'(n1),
           jss_pkg::angle_t'(n2), jss_pkg::angle_t'(n3)};
    target_angle_0 <= tg[0];
    target_angle_1 <= tg[1];
    target_angle_2 <= tg[2];
    target_angle_3 <= tg[3];
    near_angle_0   <= nr[0];
    near_angle_1   <= nr[1];
    near_angle_2   <= nr[2];
    near_angle_3   <= nr[3];
    steer_valid    <= 1'b1;
    valid_held = 1'b1;
    do @(posedge clk); while (steer_stall !== 1'b0);
    expected_steers.insert(expected_steers.size(), steer_predict(tg, nr, step_limit_now));
    if ($urandom_range(99) < send_idle_pct) begin
      steer_valid <= 1'b0;
      valid_held = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Random item: wide noise, in-range pairs, or near/target close to the limit
  task automatic send_random_steer();
    int t [LANES];
    int n [LANES];
    int span;
    int mode;
    span = int'(step_limit_now) * 5 / 4 + 2;
    if (span > 12000) begin
      span = 12000;
    end
    mode = $urandom_range(9);
    for (int i = 0; i < LANES; i++) begin
      if (mode == 0) begin
        t[i] = int'($urandom_range(32767)) - 16384;
        n[i] = int'($urandom_range(32767)) - 16384;
      end else if (mode < 4) begin
        t[i] = int'($urandom_range(23039)) - 11520;
        n[i] = int'($urandom_range(23039)) - 11520;
      end else begin
        n[i] = int'($urandom_range(23039)) - 11520;
        t[i] = n[i] + int'($urandom_range(2 * span)) - span;
      end
    end
    send_steer(t[0], t[1], t[2], t[3], n[0], n[1], n[2], n[3]);
  endtask

  // Drop valid, drain every expected result, then let the pipeline settle
  task automatic wait_idle();
    if (valid_held) begin
      steer_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (expected_steers.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_step_limit(input jss_pkg::limit_t value);
    wait_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    step_limit_now = value;
  endtask

  // Check each result against the oldest expectation, then pick the next stall
  always @(posedge clk) begin : check_results
    steer_out_t      want;
    jss_pkg::angle_t got [LANES];
    got = '{new_angle_0, new_angle_1, new_angle_2, new_angle_3};
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_steers.size() == 0) begin
        report_mismatch("result with no steer item outstanding");
      end else begin
        want = expected_steers.pop_front();
        for (int i = 0; i < LANES; i++) begin
          if (got[i] !== want.angle[i]) begin
            report_mismatch($sformatf("new_angle_%0d got %0d, expected %0d",
                                      i, got[i], want.angle[i]));
          end
        end
        if (was_reduced !== want.reduced) begin
          report_mismatch($sformatf("was_reduced got %b, expected %b",
                                    was_reduced, want.reduced));
        end
      end
    end
    result_stall <= (hold_cycles != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Reset limit: boundaries, seam crossing, out-of-range angles
  task automatic test_reset_limit();
    send_steer(0, 0, 0, 0, 0, 0, 0, 0);
    send_steer(640, 0, 0, 0, 0, 0, 0, 0);
    send_steer(-641, 0, 0, 0, 0, 0, 0, 0);
    send_steer(11519, 0, 0, 0, -11520, 0, 0, 0);
    send_steer(-11520, -11520, -11520, -11520, 11519, 11519, 11519, 11519);
    send_steer(16383, 16383, 16383, 16383, -16384, -16384, -16384, -16384);
    send_steer(-16384, -16384, -16384, -16384, 16383, 16383, 16383, 16383);
    send_steer(16000, -16000, 15990, -15990, 15990, -15990, 16000, -16000);
    send_steer(100, 200, -300, -5000, 0, 0, 0, 3000);
    send_steer(3000, -3000, 3000, -3000, 0, 0, 0, 0);
    send_steer(0, 0, 0, 0, 11520, -11520, 5760, -5760);
    send_steer(1, 2, 3, 4, -1, -2, -3, -4);
  endtask

  // Zero limit: any motion collapses to the wrapped near state
  task automatic test_zero_limit();
    write_step_limit('0);
    send_steer(16000, -16000, 12000, -12000, 16000, -16000, 12000, -12000);
    send_steer(1, 0, 0, 0, 0, 0, 0, 0);
    send_steer(-16384, 5, 0, 0, 16383, 5, 0, 0);
  endtask

  // Limits at, above and just below a half turn
  task automatic test_wide_limits();
    write_step_limit(jss_pkg::limit_t'(11520));
    send_steer(0, 0, 0, 0, 11520, -11520, 5760, -5760);
    send_steer(16383, -16384, 11519, -11520, -16384, 16383, -11520, 11519);
    write_step_limit(jss_pkg::limit_t'(16383));
    send_steer(0, 0, 0, 0, 11520, -11520, 5760, -5760);
    send_steer(16383, -16384, 11519, -11520, -16384, 16383, -11520, 11519);
    write_step_limit(jss_pkg::limit_t'(11519));
    send_steer(0, 0, 0, 0, 11520, -11520, 5760, -5760);
  endtask

  // Random traffic under each sender/receiver idle mix, new limit per mix
  task automatic test_idle_phases();
    int send_mix [4];
    int recv_mix [4];
    send_mix = '{0, 51, 0, 13};
    recv_mix = '{0, 0, 51, 13};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_step_limit(jss_pkg::limit_t'($urandom_range(1500, 1)));
        1: write_step_limit(jss_pkg::limit_t'($urandom_range(16383)));
        2: write_step_limit(jss_pkg::limit_t'(1));
        default: write_step_limit(jss_pkg::STEP_LIMIT_RESET);
      endcase
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      repeat (PHASE_ITEMS) send_random_steer();
    end
  endtask

  // Hold off results long enough that the core fills and stalls its input
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (60) send_random_steer();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_limit();
    test_zero_limit();
    test_wide_limits();
    test_idle_phases();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
